[sv/rbm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rbm_pkg
// Shared types and constants for the RAID logical block mapper.
// ----------------------------------------------------------------------------
package rbm_pkg;

   localparam int BLOCK_BITS_DEFAULT = 32;
   localparam int DIV_STEP_BITS      = 4;
   localparam int IN_W               = 32;
   localparam int DISK_W             = 15;
   localparam int STRIPE_W           = 32;
   localparam int CSR_INDEX_W        = 2;
   localparam int CSR_DATA_W         = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_RAID_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISK_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHUNK_SIZE = 2'd2;

   typedef enum logic [2:0] {
      MODE_RAID0  = 3'd0,
      MODE_RAID1  = 3'd1,
      MODE_RAID01 = 3'd2,
      MODE_RAID10 = 3'd3,
      MODE_RAID4  = 3'd4,
      MODE_RAID5  = 3'd5
   } raid_mode_type;

   // effective configuration, divisors already clamped
   typedef struct packed {
      raid_mode_type mode;
      logic [7:0]    disks;
      logic [7:0]    chunk;
      logic [7:0]    half;
      logic [7:0]    less;
   } cfg_type;

endpackage
`default_nettype wire

[sv/rbm_div_pipe.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rbm_div_pipe
// Pipelined restoring divider by an 8-bit divisor, a few quotient bits per
// stage, with a sideband word carried alongside each item.
// ----------------------------------------------------------------------------
module rbm_div_pipe #(
   parameter int DIV_W  = rbm_pkg::BLOCK_BITS_DEFAULT,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              in_valid,
   input  wire logic [DIV_W-1:0]  in_dividend,
   input  wire logic [7:0]        in_divisor,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [DIV_W-1:0]       out_quotient,
   output logic [7:0]             out_remainder,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int STEP       = rbm_pkg::DIV_STEP_BITS;
   localparam int NUM_STAGES = (DIV_W + STEP - 1) / STEP;
   localparam int PAD_W      = NUM_STAGES * STEP;

   logic              valid_ff [NUM_STAGES];
   logic [7:0]        rem_ff   [NUM_STAGES];
   logic [PAD_W-1:0]  work_ff  [NUM_STAGES];
   logic [SIDE_W-1:0] side_ff  [NUM_STAGES];
   logic [8:0]        divisor_ext;

   assign divisor_ext = {1'b0, in_divisor};

   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
      logic              valid_in;
      logic [SIDE_W-1:0] side_in;
      logic [7:0]        rem_c  [STEP+1];
      logic [PAD_W-1:0]  work_c [STEP+1];

      if (k == 0) begin : g_first
         assign valid_in  = in_valid;
         assign side_in   = in_side;
         assign rem_c[0]  = 8'd0;
         assign work_c[0] = PAD_W'(in_dividend);
      end else begin : g_next
         assign valid_in  = valid_ff[k-1];
         assign side_in   = side_ff[k-1];
         assign rem_c[0]  = rem_ff[k-1];
         assign work_c[0] = work_ff[k-1];
      end

      // dividend bits shift out the top, quotient bits shift in the bottom
      for (genvar s = 0; s < STEP; s++) begin : g_step
         logic [8:0] trial;
         logic       fits;
         assign trial       = {rem_c[s], work_c[s][PAD_W-1]};
         assign fits        = (trial >= divisor_ext);
         assign rem_c[s+1]  = fits ? 8'(trial - divisor_ext) : trial[7:0];
         assign work_c[s+1] = {work_c[s][PAD_W-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_in;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_c[STEP];
            work_ff[k] <= work_c[STEP];
            side_ff[k] <= side_in;
         end
      end
   end

   assign out_valid     = valid_ff[NUM_STAGES-1];
   assign out_quotient  = work_ff[NUM_STAGES-1][DIV_W-1:0];
   assign out_remainder = rem_ff[NUM_STAGES-1];
   assign out_side      = side_ff[NUM_STAGES-1];

endmodule
`default_nettype wire

[sv/rbm_finish.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rbm_finish
// Multiply stage and output register: assembles disk, stripe and second disk
// for the configured layout from the quotients and remainders.
// ----------------------------------------------------------------------------
module rbm_finish (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire rbm_pkg::cfg_type              cfg,
   input  wire logic                          in_valid,
   input  wire logic [rbm_pkg::STRIPE_W-1:0]  in_q1,
   input  wire logic [7:0]                    in_r1,
   input  wire logic [7:0]                    in_rb,
   input  wire logic [rbm_pkg::STRIPE_W-1:0]  in_q2,
   input  wire logic [7:0]                    in_r2,
   output logic                               out_valid,
   output logic [rbm_pkg::DISK_W-1:0]         out_disk_index,
   output logic [rbm_pkg::STRIPE_W-1:0]       out_stripe_index,
   output logic [rbm_pkg::DISK_W-1:0]         out_second_disk,
   output logic                               out_has_second
);

   localparam int DW = rbm_pkg::DISK_W;
   localparam int SW = rbm_pkg::STRIPE_W;

   // multiply stage
   logic          valid_m_ff;
   logic [SW-1:0] prod0_ff;
   logic [DW-1:0] prod10_ff;
   logic [SW-1:0] q1_ff;
   logic [7:0]    r1_ff;
   logic [7:0]    rb_ff;
   logic [7:0]    r2_ff;
   logic [8:0]    chunk_plus;
   logic [16:0]   prod10_in;
   logic [SW-1:0] prod0_in;

   // output stage
   logic          valid_o_ff;
   logic [DW-1:0] disk_ff;
   logic [SW-1:0] stripe_ff;
   logic [DW-1:0] second_ff;
   logic          has_ff;
   logic [DW-1:0] disk_in;
   logic [SW-1:0] stripe_in;
   logic [DW-1:0] second_in;
   logic          has_in;

   assign chunk_plus = {1'b0, cfg.chunk} + 9'd1;
   assign prod10_in  = {9'd0, in_r1} * {8'd0, chunk_plus};
   assign prod0_in   = SW'(in_q2 * cfg.chunk);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_m_ff <= 1'b0;
      end else if (advance) begin
         valid_m_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod0_ff  <= prod0_in;
         prod10_ff <= prod10_in[DW-1:0];
         q1_ff     <= in_q1;
         r1_ff     <= in_r1;
         rb_ff     <= in_rb;
         r2_ff     <= in_r2;
      end
   end

   always_comb begin
      disk_in   = DW'(r2_ff);
      stripe_in = prod0_ff + SW'(r1_ff);
      second_in = '0;
      has_in    = 1'b0;
      case (cfg.mode)
         rbm_pkg::MODE_RAID1: begin
            disk_in   = '0;
            stripe_in = q1_ff;
            second_in = DW'(1);
            has_in    = 1'b1;
         end
         rbm_pkg::MODE_RAID01: begin
            disk_in   = DW'(r1_ff);
            stripe_in = q1_ff;
            second_in = DW'(r1_ff) + DW'(cfg.half);
            has_in    = 1'b1;
         end
         rbm_pkg::MODE_RAID10: begin
            disk_in   = prod10_ff;
            stripe_in = q1_ff;
            second_in = prod10_ff + DW'(1);
            has_in    = 1'b1;
         end
         rbm_pkg::MODE_RAID4: begin
            disk_in   = DW'(r1_ff);
            stripe_in = q1_ff;
            second_in = DW'(cfg.less);
            has_in    = 1'b1;
         end
         rbm_pkg::MODE_RAID5: begin
            disk_in   = DW'(rb_ff);
            stripe_in = q1_ff;
            second_in = DW'(cfg.less) - DW'(r2_ff);
            has_in    = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_o_ff <= 1'b0;
      end else if (advance) begin
         valid_o_ff <= valid_m_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         disk_ff   <= disk_in;
         stripe_ff <= stripe_in;
         second_ff <= second_in;
         has_ff    <= has_in;
      end
   end

   assign out_valid        = valid_o_ff;
   assign out_disk_index   = disk_ff;
   assign out_stripe_index = stripe_ff;
   assign out_second_disk  = second_ff;
   assign out_has_second   = has_ff;

endmodule
`default_nettype wire

[sv/raid_block_mapper_top.sv]
`default_nettype none
// Throughput: one item per cycle; two chained divider pipelines, four quotient
// bits per stage, set the depth. The whole pipeline stalls while rsp is held.
// Reset: synchronous, active high; clears all valid bits and loads
// raid_mode 0, disk_count 2, chunk_size 1.
// ----------------------------------------------------------------------------
// raid_block_mapper_top
// Maps a logical block number to disk, stripe and mirror or parity disk for
// RAID 0, 1, 0+1, 1+0, 4 and 5 layouts.
// ----------------------------------------------------------------------------
module raid_block_mapper_top #(
   parameter int BLOCK_BITS = rbm_pkg::BLOCK_BITS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [rbm_pkg::IN_W-1:0]         req_block_number,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [rbm_pkg::DISK_W-1:0]            rsp_disk_index,
   output logic [rbm_pkg::STRIPE_W-1:0]          rsp_stripe_index,
   output logic [rbm_pkg::DISK_W-1:0]            rsp_second_disk,
   output logic                                  rsp_has_second,
   input  wire logic                             csr_wr_en,
   input  wire logic [rbm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [rbm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int SW     = rbm_pkg::STRIPE_W;
   localparam int SIDE_W = SW + 16;

   rbm_pkg::raid_mode_type mode_ff;
   logic [7:0]             disks_ff;
   logic [7:0]             chunk_ff;
   rbm_pkg::cfg_type       cfg;

   logic                  advance;
   logic [BLOCK_BITS-1:0] block;
   logic [7:0]            div1;

   logic                  q1_valid;
   logic [BLOCK_BITS-1:0] q1;
   logic [7:0]            r1;
   logic [7:0]            rb;
   logic [SIDE_W-1:0]     side2_in;
   logic [SIDE_W-1:0]     side2;
   logic                  q2_valid;
   logic [BLOCK_BITS-1:0] q2;
   logic [7:0]            r2;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= rbm_pkg::MODE_RAID0;
         disks_ff <= 8'd2;
         chunk_ff <= 8'd1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rbm_pkg::CSR_RAID_MODE:  mode_ff  <= rbm_pkg::raid_mode_type'(csr_wdata[2:0]);
            rbm_pkg::CSR_DISK_COUNT: disks_ff <= (csr_wdata < 8'd2) ? 8'd2 : csr_wdata;
            rbm_pkg::CSR_CHUNK_SIZE: chunk_ff <= (csr_wdata == 8'd0) ? 8'd1 : csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg.mode  = mode_ff;
   assign cfg.disks = disks_ff;
   assign cfg.chunk = chunk_ff;
   assign cfg.half  = {1'b0, disks_ff[7:1]};
   assign cfg.less  = disks_ff - 8'd1;

   // first divisor; raid1 divides by one so the quotient is the block itself
   always_comb begin
      case (cfg.mode) inside
         rbm_pkg::MODE_RAID1:                       div1 = 8'd1;
         rbm_pkg::MODE_RAID01, rbm_pkg::MODE_RAID10: div1 = cfg.half;
         rbm_pkg::MODE_RAID4, rbm_pkg::MODE_RAID5:   div1 = cfg.less;
         default:                                   div1 = cfg.chunk;
      endcase
   end

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign block     = BLOCK_BITS'(req_block_number);

   rbm_div_pipe #(
      .DIV_W  (BLOCK_BITS),
      .SIDE_W (1)
   ) u_div_a (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (req_valid),
      .in_dividend   (block),
      .in_divisor    (div1),
      .in_side       (1'b0),
      .out_valid     (q1_valid),
      .out_quotient  (q1),
      .out_remainder (r1),
      .out_side      ()
   );

   // block modulo disk count, used by raid5
   rbm_div_pipe #(
      .DIV_W  (BLOCK_BITS),
      .SIDE_W (1)
   ) u_div_b (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (req_valid),
      .in_dividend   (block),
      .in_divisor    (cfg.disks),
      .in_side       (1'b0),
      .out_valid     (),
      .out_quotient  (),
      .out_remainder (rb),
      .out_side      ()
   );

   assign side2_in = {r1, rb, SW'(q1)};

   rbm_div_pipe #(
      .DIV_W  (BLOCK_BITS),
      .SIDE_W (SIDE_W)
   ) u_div_c (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (q1_valid),
      .in_dividend   (q1),
      .in_divisor    (cfg.disks),
      .in_side       (side2_in),
      .out_valid     (q2_valid),
      .out_quotient  (q2),
      .out_remainder (r2),
      .out_side      (side2)
   );

   rbm_finish u_finish (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .cfg              (cfg),
      .in_valid         (q2_valid),
      .in_q1            (side2[SW-1:0]),
      .in_r1            (side2[SIDE_W-1:SIDE_W-8]),
      .in_rb            (side2[SW+7:SW]),
      .in_q2            (SW'(q2)),
      .in_r2            (r2),
      .out_valid        (rsp_valid),
      .out_disk_index   (rsp_disk_index),
      .out_stripe_index (rsp_stripe_index),
      .out_second_disk  (rsp_second_disk),
      .out_has_second   (rsp_has_second)
   );

endmodule
`default_nettype wire
